FILE: src/kst_pkg.sv
// Shared types, constants and character tables for the scan code translator.
package kst_pkg;

  localparam logic [7:0] LED_COMMAND       = 8'hed;
  localparam logic [7:0] CASE_OFFSET       = 8'h20;
  localparam logic [7:0] CODE_LSHIFT_MAKE  = 8'h2a;
  localparam logic [7:0] CODE_RSHIFT_MAKE  = 8'h36;
  localparam logic [7:0] CODE_LSHIFT_BREAK = 8'haa;
  localparam logic [7:0] CODE_RSHIFT_BREAK = 8'hb6;
  localparam logic [7:0] CODE_CAPS         = 8'h3a;
  localparam logic [7:0] CODE_NUM          = 8'h45;
  localparam logic [7:0] CODE_SCROLL       = 8'h46;
  localparam logic [7:0] CODE_RELEASE      = 8'h80;

  localparam logic       KIND_CHAR    = 1'b0;
  localparam logic       KIND_COMMAND = 1'b1;

  localparam logic [2:0] LED_CAPS   = 3'b100;
  localparam logic [2:0] LED_NUM    = 3'b010;
  localparam logic [2:0] LED_SCROLL = 3'b001;

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
    logic       last;
  } result_t;

  // Results of one scan code together with the state it leaves behind.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
    logic [1:0] shift_next;
    logic [2:0] leds_next;
  } dec_t;

  // Beats handed to the result queue in one cycle.
  typedef struct packed {
    logic       valid;
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic logic [7:0] rom_plain(input logic [6:0] code);
    logic [7:0] ch;
    case (code)
      7'h02: ch = 8'h31;  7'h03: ch = 8'h32;  7'h04: ch = 8'h33;  7'h05: ch = 8'h34;
      7'h06: ch = 8'h35;  7'h07: ch = 8'h36;  7'h08: ch = 8'h37;  7'h09: ch = 8'h38;
      7'h0a: ch = 8'h39;  7'h0b: ch = 8'h30;  7'h0c: ch = 8'h2d;  7'h0d: ch = 8'h5e;
      7'h0e: ch = 8'h08;
      7'h10: ch = 8'h51;  7'h11: ch = 8'h57;  7'h12: ch = 8'h45;  7'h13: ch = 8'h52;
      7'h14: ch = 8'h54;  7'h15: ch = 8'h59;  7'h16: ch = 8'h55;  7'h17: ch = 8'h49;
      7'h18: ch = 8'h4f;  7'h19: ch = 8'h50;  7'h1a: ch = 8'h40;  7'h1b: ch = 8'h5b;
      7'h1c: ch = 8'h0a;  7'h1e: ch = 8'h41;  7'h1f: ch = 8'h53;
      7'h20: ch = 8'h44;  7'h21: ch = 8'h46;  7'h22: ch = 8'h47;  7'h23: ch = 8'h48;
      7'h24: ch = 8'h4a;  7'h25: ch = 8'h4b;  7'h26: ch = 8'h4c;  7'h27: ch = 8'h3b;
      7'h28: ch = 8'h3a;  7'h2b: ch = 8'h5d;  7'h2c: ch = 8'h5a;  7'h2d: ch = 8'h58;
      7'h2e: ch = 8'h43;  7'h2f: ch = 8'h56;
      7'h30: ch = 8'h42;  7'h31: ch = 8'h4e;  7'h32: ch = 8'h4d;  7'h33: ch = 8'h2c;
      7'h34: ch = 8'h2e;  7'h35: ch = 8'h2f;  7'h37: ch = 8'h2a;  7'h39: ch = 8'h20;
      7'h47: ch = 8'h37;  7'h48: ch = 8'h38;  7'h49: ch = 8'h39;  7'h4a: ch = 8'h2d;
      7'h4b: ch = 8'h34;  7'h4c: ch = 8'h35;  7'h4d: ch = 8'h36;  7'h4e: ch = 8'h2b;
      7'h4f: ch = 8'h31;
      7'h50: ch = 8'h32;  7'h51: ch = 8'h33;  7'h52: ch = 8'h30;  7'h53: ch = 8'h2e;
      7'h73: ch = 8'h5c;  7'h7d: ch = 8'h5c;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // The shifted layout differs from the plain one only on these keys.
  function automatic logic [7:0] rom_shifted(input logic [6:0] code);
    logic [7:0] ch;
    case (code)
      7'h02: ch = 8'h21;  7'h03: ch = 8'h22;  7'h04: ch = 8'h23;  7'h05: ch = 8'h24;
      7'h06: ch = 8'h25;  7'h07: ch = 8'h26;  7'h08: ch = 8'h27;  7'h09: ch = 8'h28;
      7'h0a: ch = 8'h29;  7'h0b: ch = 8'h7e;  7'h0c: ch = 8'h3d;  7'h0d: ch = 8'h7e;
      7'h1a: ch = 8'h60;  7'h1b: ch = 8'h7b;  7'h27: ch = 8'h2b;  7'h28: ch = 8'h2a;
      7'h2b: ch = 8'h7d;  7'h33: ch = 8'h3c;  7'h34: ch = 8'h3e;  7'h35: ch = 8'h3f;
      7'h73: ch = 8'h5f;  7'h7d: ch = 8'h7c;
      default: ch = rom_plain(code);
    endcase
    return ch;
  endfunction

endpackage

FILE: src/kst_if.sv
// Valid/ready channels for scan codes in and translated results out.
interface kst_scan_if;
  logic       valid;
  logic       ready;
  logic [7:0] scan_code;

  modport source (output valid, output scan_code, input ready);
  modport sink (input valid, input scan_code, output ready);
endinterface

interface kst_result_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] value;
  logic       last;

  modport source (output valid, output kind, output value, output last, input ready);
  modport sink (input valid, input kind, input value, input last, output ready);
endinterface

FILE: src/kst_decode.sv
// Translates one registered scan code into its result beats and next state.
module kst_decode (
  input  logic [7:0]    code,
  input  logic [1:0]    shift_flags,
  input  logic [2:0]    lock_leds,
  output kst_pkg::dec_t dec
);

  logic [7:0] ch_raw;
  logic [7:0] ch;
  logic       shifted;
  logic       caps;
  logic [2:0] toggle;

  assign shifted = (shift_flags != 2'b00);
  assign caps    = (lock_leds & kst_pkg::LED_CAPS) != 3'b000;

  always_comb begin
    if (code >= kst_pkg::CODE_RELEASE) begin
      ch_raw = 8'h00;
    end else if (shifted) begin
      ch_raw = kst_pkg::rom_shifted(code[6:0]);
    end else begin
      ch_raw = kst_pkg::rom_plain(code[6:0]);
    end
    // Letters come out of the tables in upper case.
    if (ch_raw >= 8'h41 && ch_raw <= 8'h5a && caps == shifted) begin
      ch = ch_raw + kst_pkg::CASE_OFFSET;
    end else begin
      ch = ch_raw;
    end
  end

  always_comb begin
    dec.shift_next = shift_flags;
    toggle         = 3'b000;
    case (code)
      kst_pkg::CODE_LSHIFT_MAKE:  dec.shift_next = shift_flags | 2'b01;
      kst_pkg::CODE_RSHIFT_MAKE:  dec.shift_next = shift_flags | 2'b10;
      kst_pkg::CODE_LSHIFT_BREAK: dec.shift_next = shift_flags & 2'b10;
      kst_pkg::CODE_RSHIFT_BREAK: dec.shift_next = shift_flags & 2'b01;
      kst_pkg::CODE_CAPS:         toggle = kst_pkg::LED_CAPS;
      kst_pkg::CODE_NUM:          toggle = kst_pkg::LED_NUM;
      kst_pkg::CODE_SCROLL:       toggle = kst_pkg::LED_SCROLL;
      default:                    toggle = 3'b000;
    endcase
    dec.leds_next     = lock_leds ^ toggle;
    dec.second.kind   = kst_pkg::KIND_COMMAND;
    dec.second.value  = {5'b00000, dec.leds_next};
    dec.second.last   = 1'b1;
    if (toggle != 3'b000) begin
      dec.count       = 2'd2;
      dec.first.kind  = kst_pkg::KIND_COMMAND;
      dec.first.value = kst_pkg::LED_COMMAND;
      dec.first.last  = 1'b0;
    end else begin
      dec.count       = (ch != 8'h00) ? 2'd1 : 2'd0;
      dec.first.kind  = kst_pkg::KIND_CHAR;
      dec.first.value = ch;
      dec.first.last  = 1'b1;
    end
  end

endmodule

FILE: src/kst_result_queue.sv
// Three-entry result queue: takes up to two beats per cycle while it has room, gives one while result.ready is high.
module kst_result_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  kst_pkg::push_t       push,
  output logic                 room,
  kst_result_if.source         result
);

  kst_pkg::result_t entry [3];
  kst_pkg::result_t entry_next [3];
  logic [1:0]       count;
  logic [1:0]       count_next;
  logic [1:0]       base;
  logic             pop;

  assign pop  = (count != 2'd0) && result.ready;
  assign room = (count <= 2'd1);
  assign base = count - {1'b0, pop};

  assign result.valid = (count != 2'd0);
  assign result.kind  = entry[0].kind;
  assign result.value = entry[0].value;
  assign result.last  = entry[0].last;

  always_comb begin
    if (pop) begin
      entry_next[0] = entry[1];
      entry_next[1] = entry[2];
      entry_next[2] = entry[2];
    end else begin
      entry_next = entry;
    end
    for (int i = 0; i < 3; i++) begin
      if (push.valid && base == 2'(i)) begin
        entry_next[i] = push.first;
      end
      if (push.valid && push.count == 2'd2 && base + 2'd1 == 2'(i)) begin
        entry_next[i] = push.second;
      end
    end
    count_next = push.valid ? base + push.count : base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      entry[i] <= entry_next[i];
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> ({1'b0, count} - {2'b00, pop} + {1'b0, push.count}) <= 3'd3)
    else $error("result queue overflow");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !push.valid && !pop |=> count == $past(count))
    else $error("result queue count changed without a beat");

endmodule

FILE: src/keyboard_scancode_translator_core.sv
// Keyboard scan code translator top level: input register, decode, state and result queue.
// One scan code beat is taken per cycle while the queue has room, and its results pass through
// the input register and then the three-entry result queue before they can be taken. A lock
// key yields two command beats (0xED, then the LED bits), so a run of lock keys is paced by
// the single-beat output port of the queue. Writing initial_leds loads the lock LED state at
// once; write it only while no scan code is in flight.
module keyboard_scancode_translator_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         initial_leds_we,
  input  logic [2:0]   initial_leds,
  kst_scan_if.sink     scan,
  kst_result_if.source result
);

  logic           in_valid;
  logic [7:0]     code;
  logic [1:0]     shift_flags;
  logic [2:0]     lock_leds;
  logic           room;
  logic           fire;
  kst_pkg::dec_t  dec;
  kst_pkg::push_t push;

  assign fire       = in_valid && room;
  assign scan.ready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (scan.valid && scan.ready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan.valid && scan.ready) begin
      code <= scan.scan_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_flags <= 2'b00;
      lock_leds   <= 3'b000;
    end else begin
      if (fire) begin
        shift_flags <= dec.shift_next;
      end
      if (initial_leds_we) begin
        lock_leds <= initial_leds;
      end else if (fire) begin
        lock_leds <= dec.leds_next;
      end
    end
  end

  kst_decode u_decode (
    .code        (code),
    .shift_flags (shift_flags),
    .lock_leds   (lock_leds),
    .dec         (dec)
  );

  assign push.valid  = fire && (dec.count != 2'd0);
  assign push.count  = dec.count;
  assign push.first  = dec.first;
  assign push.second = dec.second;

  kst_result_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .room   (room),
    .result (result)
  );

  a_leds_load: assert property (@(posedge clk) disable iff (rst)
    initial_leds_we |=> lock_leds == $past(initial_leds))
    else $error("lock LEDs not loaded by register write");

  a_pair_head: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.last |-> result.kind == kst_pkg::KIND_COMMAND
      && result.value == kst_pkg::LED_COMMAND)
    else $error("non-final beat is not the LED command");

  a_lshift_set: assert property (@(posedge clk) disable iff (rst)
    fire && code == kst_pkg::CODE_LSHIFT_MAKE |=> shift_flags[0])
    else $error("left shift flag not set");

endmodule

FILE: verif/keyboard_scancode_translator_core_test.sv
// Self-checking testbench for the keyboard scan code translator core.
module keyboard_scancode_translator_core_test;
  import kst_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 6;
  localparam int TAIL_CYCLES = 12;
  localparam int MAX_REPORTS = 40;
  localparam int PHASE_CODES = 78;
  localparam int DIRECTED_ROWS = 25;
  localparam logic [7:0] UPPER_A = 8'h41;
  localparam logic [7:0] UPPER_Z = 8'h5a;

  localparam result_t NO_BEAT = '0;
  localparam result_t LED_CMD_BEAT = '{KIND_COMMAND, LED_COMMAND, 1'b0};

  typedef struct packed {
    logic [7:0] code;
    logic       typed;
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } key_row_t;

  logic clk = 1'b0;
  logic rst;
  logic leds_we;
  logic [2:0] leds_data;

  kst_scan_if scan_ch();
  kst_result_if res_ch();

  keyboard_scancode_translator_core DUT (
    .clk(clk),
    .rst(rst),
    .initial_leds_we(leds_we),
    .initial_leds(leds_data),
    .scan(scan_ch),
    .result(res_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Japanese layout, scan code set 1, unshifted and shifted.
  logic [7:0] plain_map [0:127] = '{
    'h00, 'h00, 'h31, 'h32, 'h33, 'h34, 'h35, 'h36, 'h37, 'h38, 'h39, 'h30, 'h2d, 'h5e, 'h08, 'h00,
    'h51, 'h57, 'h45, 'h52, 'h54, 'h59, 'h55, 'h49, 'h4f, 'h50, 'h40, 'h5b, 'h0a, 'h00, 'h41, 'h53,
    'h44, 'h46, 'h47, 'h48, 'h4a, 'h4b, 'h4c, 'h3b, 'h3a, 'h00, 'h00, 'h5d, 'h5a, 'h58, 'h43, 'h56,
    'h42, 'h4e, 'h4d, 'h2c, 'h2e, 'h2f, 'h00, 'h2a, 'h00, 'h20, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
    'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h37, 'h38, 'h39, 'h2d, 'h34, 'h35, 'h36, 'h2b, 'h31,
    'h32, 'h33, 'h30, 'h2e, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
    'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
    'h00, 'h00, 'h00, 'h5c, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h5c, 'h00, 'h00
  };

  logic [7:0] shifted_map [0:127] = '{
    'h00, 'h00, 'h21, 'h22, 'h23, 'h24, 'h25, 'h26, 'h27, 'h28, 'h29, 'h7e, 'h3d, 'h7e, 'h08, 'h00,
    'h51, 'h57, 'h45, 'h52, 'h54, 'h59, 'h55, 'h49, 'h4f, 'h50, 'h60, 'h7b, 'h0a, 'h00, 'h41, 'h53,
    'h44, 'h46, 'h47, 'h48, 'h4a, 'h4b, 'h4c, 'h2b, 'h2a, 'h00, 'h00, 'h7d, 'h5a, 'h58, 'h43, 'h56,
    'h42, 'h4e, 'h4d, 'h3c, 'h3e, 'h3f, 'h00, 'h2a, 'h00, 'h20, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
    'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h37, 'h38, 'h39, 'h2d, 'h34, 'h35, 'h36, 'h2b, 'h31,
    'h32, 'h33, 'h30, 'h2e, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
    'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
    'h00, 'h00, 'h00, 'h5f, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h7c, 'h00, 'h00
  };

  // Rows with typed = 0 take their results from the translation below.
  key_row_t directed_rows [DIRECTED_ROWS] = '{
    '{8'h1e, 1'b1, 2'd1, '{KIND_CHAR, 8'h61, 1'b1}, NO_BEAT},
    '{8'h00, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{8'h7f, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{CODE_RELEASE, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{8'hff, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{8'h02, 1'b1, 2'd1, '{KIND_CHAR, 8'h31, 1'b1}, NO_BEAT},
    '{8'h73, 1'b1, 2'd1, '{KIND_CHAR, 8'h5c, 1'b1}, NO_BEAT},
    '{CODE_CAPS, 1'b1, 2'd2, LED_CMD_BEAT, '{KIND_COMMAND, {5'd0, LED_CAPS}, 1'b1}},
    '{8'h10, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{CODE_LSHIFT_MAKE, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{8'h10, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{8'h02, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{CODE_RSHIFT_MAKE, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{CODE_LSHIFT_BREAK, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{8'h7d, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{CODE_RSHIFT_BREAK, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{8'h1e, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{CODE_CAPS, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{CODE_NUM, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{CODE_SCROLL, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{CODE_CAPS | CODE_RELEASE, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{8'h39, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{CODE_LSHIFT_MAKE, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{8'h1e, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{CODE_LSHIFT_BREAK, 1'b1, 2'd0, NO_BEAT, NO_BEAT}
  };

  logic [1:0] shift_held;
  logic [2:0] lock_state;
  result_t translated_due [$];
  int errors = 0;
  int codes_sent = 0;
  int beats_checked = 0;
  int led_loads = 0;
  bit send_calm = 1'b0;
  bit take_calm = 1'b0;

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= MAX_REPORTS) $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  // Works out the beats one scan code yields and advances the keyboard state.
  function automatic void translate_scan(input logic [7:0] code, output int count,
                                         output result_t first, output result_t second);
    logic [7:0] ch;
    logic [2:0] toggle;
    ch = 8'h00;
    toggle = 3'b000;
    count = 0;
    first = NO_BEAT;
    second = NO_BEAT;
    if (code < CODE_RELEASE) ch = (shift_held == 2'b00) ? plain_map[code[6:0]]
                                                         : shifted_map[code[6:0]];
    // Letters come out in lower case unless caps lock and shift disagree.
    if (ch >= UPPER_A && ch <= UPPER_Z && (lock_state[2] == (shift_held != 2'b00)))
      ch = ch + CASE_OFFSET;
    case (code)
      CODE_LSHIFT_MAKE: shift_held[0] = 1'b1;
      CODE_RSHIFT_MAKE: shift_held[1] = 1'b1;
      CODE_LSHIFT_BREAK: shift_held[0] = 1'b0;
      CODE_RSHIFT_BREAK: shift_held[1] = 1'b0;
      CODE_CAPS: toggle = LED_CAPS;
      CODE_NUM: toggle = LED_NUM;
      CODE_SCROLL: toggle = LED_SCROLL;
      default: ;
    endcase
    if (toggle != 3'b000) begin
      lock_state = lock_state ^ toggle;
      count = 2;
      first = LED_CMD_BEAT;
      second = '{KIND_COMMAND, {5'd0, lock_state}, 1'b1};
    end else if (ch != 8'h00) begin
      count = 1;
      first = '{KIND_CHAR, ch, 1'b1};
    end
  endfunction

  // Called just after a falling edge; returns just after the falling edge that follows
  // the accepting beat.
  task automatic send_scan(input logic [7:0] code, input logic typed,
                           input logic [1:0] typed_count, input result_t typed_first,
                           input result_t typed_second);
    int gap;
    int count;
    result_t first;
    result_t second;
    if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      scan_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    scan_ch.valid = 1'b1;
    scan_ch.scan_code = code;
    do @(posedge clk); while (!scan_ch.ready);
    translate_scan(code, count, first, second);
    if (typed) begin
      count = typed_count;
      first = typed_first;
      second = typed_second;
    end
    if (count > 0) translated_due.push_back(first);
    if (count > 1) translated_due.push_back(second);
    codes_sent++;
    @(negedge clk);
  endtask

  task automatic send_code(input logic [7:0] code);
    send_scan(code, 1'b0, 2'd0, NO_BEAT, NO_BEAT);
  endtask

  // The LED register may only change with nothing in flight.
  task automatic load_leds(input logic [2:0] leds);
    scan_ch.valid = 1'b0;
    while (translated_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    leds_we = 1'b1;
    leds_data = leds;
    @(negedge clk);
    leds_we = 1'b0;
    lock_state = leds;
    led_loads++;
  endtask

  // Mostly press and release pairs, shift and lock keys, with some raw noise bytes.
  task automatic send_key_group();
    logic [7:0] key;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        key = 8'($urandom_range(0, 127));
        send_code(key);
        send_code(key | CODE_RELEASE);
      end
      5: send_code($urandom_range(0, 1) ? CODE_LSHIFT_MAKE : CODE_RSHIFT_MAKE);
      6: send_code($urandom_range(0, 1) ? CODE_LSHIFT_BREAK : CODE_RSHIFT_BREAK);
      7: begin
        case ($urandom_range(0, 2))
          0: key = CODE_CAPS;
          1: key = CODE_NUM;
          default: key = CODE_SCROLL;
        endcase
        send_code(key);
        send_code(key | CODE_RELEASE);
      end
      default: send_code(8'($urandom_range(0, 255)));
    endcase
  endtask

  initial begin
    int stall;
    result_t want;
    res_ch.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      if ($urandom_range(0, 15) == 0) take_calm = !take_calm;
      stall = take_calm ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        res_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ch.ready = 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      beats_checked++;
      if (translated_due.size() == 0) begin
        report_mismatch($sformatf("unexpected beat kind %0d value %02h last %0d",
                                  res_ch.kind, res_ch.value, res_ch.last));
      end else begin
        want = translated_due.pop_front();
        if (res_ch.kind !== want.kind)
          report_mismatch($sformatf("kind %0d, expected %0d", res_ch.kind, want.kind));
        if (res_ch.value !== want.value)
          report_mismatch($sformatf("value %02h, expected %02h", res_ch.value, want.value));
        if (res_ch.last !== want.last)
          report_mismatch($sformatf("last %0d, expected %0d", res_ch.last, want.last));
      end
      @(negedge clk);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst !== 1'b0 || (scan_ch.valid && scan_ch.ready) || (res_ch.valid && res_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: no beat moved for %0d cycles, %0d results still due",
             WATCHDOG_LIMIT, translated_due.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [2:0] phase_leds [8];
    int target;
    rst = 1'b1;
    leds_we = 1'b0;
    leds_data = 3'd0;
    scan_ch.valid = 1'b0;
    scan_ch.scan_code = 8'h00;
    shift_held = 2'b00;
    lock_state = 3'b000;
    phase_leds = '{3'd7, 3'd0, LED_CAPS, 3'($urandom_range(0, 7)), LED_NUM | LED_SCROLL,
                   3'($urandom_range(0, 7)), LED_CAPS | LED_SCROLL, 3'd7};
    repeat (10) @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_scan(directed_rows[i].code, directed_rows[i].typed, directed_rows[i].count,
                directed_rows[i].first, directed_rows[i].second);

    for (int p = 0; p < 8; p++) begin
      load_leds(phase_leds[p]);
      target = codes_sent + PHASE_CODES;
      while (codes_sent < target) send_key_group();
    end

    scan_ch.valid = 1'b0;
    while (translated_due.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Covered %0d scan codes (%0d from the directed table) over %0d LED loads,",
             codes_sent, DIRECTED_ROWS, led_loads);
    $display("with %0d result beats compared and %0d mismatches.", beats_checked, errors);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: keyboard_scancode_translator_core.f
src/kst_pkg.sv
src/kst_if.sv
src/kst_decode.sv
src/kst_result_queue.sv
src/keyboard_scancode_translator_core.sv
verif/keyboard_scancode_translator_core_test.sv
